>>> sv/ged_pkg.sv
// Package for the Golomb-coded EEG delta decoder.
// Holds the field widths, limits, header byte positions and small helper functions.
// It has no dependencies.
package ged_pkg;

  localparam int Channels      = 4;
  localparam int SamplesPerCh  = 16;
  localparam int MaxQuotient   = 31;
  localparam int QuotW         = $clog2(MaxQuotient + 1);
  localparam int MulCntW       = $clog2(QuotW);
  localparam int MedianW       = 6;
  localparam int MaskW         = 4;
  localparam int MagW          = QuotW + MedianW + 1;
  localparam int DeltaW        = 23;
  localparam int ChanW         = 2;
  localparam int SampleW       = 4;
  localparam int ByteW         = 8;
  localparam int BitIdxW       = 3;
  localparam int HdrCntW       = 3;
  localparam int LenW          = 16;
  localparam int RemW          = 8;
  localparam int RemLeftW      = 3;
  localparam int SkipW         = 6;
  localparam int ZeroSkipBits  = 48;

  localparam logic [HdrCntW-1:0] HdrMq0   = 3'd1;
  localparam logic [HdrCntW-1:0] HdrMq1   = 3'd2;
  localparam logic [HdrCntW-1:0] HdrMq2   = 3'd3;
  localparam logic [HdrCntW-1:0] HdrMq3   = 3'd4;
  localparam logic [HdrCntW-1:0] HdrMq4   = 3'd5;
  localparam logic [HdrCntW-1:0] HdrLenHi = 3'd6;
  localparam logic [HdrCntW-1:0] HdrLenLo = 3'd7;

  function automatic logic [RemLeftW-1:0] floor_log2(input logic [MedianW-1:0] m);
    logic [RemLeftW-1:0] b;
    b = '0;
    for (int i = 1; i < MedianW; i++) begin
      if (m[i]) begin
        b = RemLeftW'(i);
      end
    end
    return b;
  endfunction

  function automatic logic [RemW-1:0] extra_thr(input logic [MedianW-1:0] m);
    return (RemW'(2) << floor_log2(m)) - RemW'(m);
  endfunction

  function automatic logic [MaskW-1:0] mask_to_shift(input logic [MaskW-1:0] mask);
    return (mask[0] ? 4'd1 : 4'd0) + (mask[1] ? 4'd2 : 4'd0) +
           (mask[2] ? 4'd3 : 4'd0) + (mask[3] ? 4'd4 : 4'd0);
  endfunction

endpackage

>>> sv/ged_in_if.sv
// Input channel of the decoder: one packet byte per item.
// Depends on ged_pkg for the byte width.
interface ged_in_if import ged_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packet_byte;
  logic             packet_end;

  modport source (output valid, output packet_byte, output packet_end, input ready);
  modport sink   (input valid, input packet_byte, input packet_end, output ready);
endinterface

>>> sv/ged_out_if.sv
// Output channel of the decoder: one decoded delta per item.
// Depends on ged_pkg for the field widths.
interface ged_out_if import ged_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DeltaW-1:0] delta_value;
  logic [ChanW-1:0]         channel_index;
  logic [SampleW-1:0]       sample_index;
  logic                     last_delta;
  logic                     length_mismatch;
  logic                     quotient_clipped;

  modport source (output valid, output delta_value, output channel_index,
                  output sample_index, output last_delta, output length_mismatch,
                  output quotient_clipped, input ready);
  modport sink   (input valid, input delta_value, input channel_index,
                  input sample_index, input last_delta, input length_mismatch,
                  input quotient_clipped, output ready);
endinterface

>>> sv/golomb_eeg_delta_decoder_core.sv
// Golomb-coded EEG delta decoder core. Each input item is one packet byte; bytes 0 to 7 form the
// header (type, medians, quantization masks, expected bit length) and are stored as they are
// accepted. Every later byte is accepted and then decoded bit-serially, and the deltas it
// completes add steps of their own: a Golomb-coded delta runs a shift-add multiply of quotient
// by median on one shared adder, then loads the output register; the end of a zero-median skip
// emits one zero delta per sample; a delta or skip that closes any channel but the last passes
// through a start state to begin the next channel; and an output stall holds the block while it
// waits to load the output register. The block takes no new byte while one is being decoded. A
// finished delta sits in an output register until taken. After the byte flagged as packet end the
// header and decoding state returns to its reset value. Depends on ged_pkg, ged_in_if and ged_out_if.
module golomb_eeg_delta_decoder_core import ged_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ged_in_if.sink    in_i,
  ged_out_if.source out_o
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_QUOT, PH_REM, PH_EXTRA, PH_SIGN, PH_SKIP, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BIT, ST_MUL, ST_EMIT, ST_ZERO, ST_START
  } state_e;

  state_e               state_q;
  phase_e               phase_q;
  logic [ByteW-1:0]     byte_q;
  logic                 end_q;
  logic [BitIdxW-1:0]   bit_idx_q;
  logic [HdrCntW-1:0]   hdr_cnt_q;
  logic [MedianW-1:0]   med_q [Channels];
  logic [MaskW-1:0]     shf_q [Channels];
  logic [LenW-1:0]      exp_q;
  logic [LenW-1:0]      cons_q;
  logic [ChanW-1:0]     ch_q;
  logic [SampleW-1:0]   sample_q;
  logic [QuotW-1:0]     quot_q;
  logic [RemW-1:0]      rem_q;
  logic [RemLeftW-1:0]  rem_left_q;
  logic [SkipW-1:0]     skip_q;
  logic [MagW-1:0]      acc_q;
  logic [MulCntW-1:0]   mul_cnt_q;
  logic                 sign_q;
  logic                 clip_q;

  logic                     out_valid_q;
  logic signed [DeltaW-1:0] out_delta_q;
  logic [ChanW-1:0]         out_ch_q;
  logic [SampleW-1:0]       out_sample_q;
  logic                     out_last_q;
  logic                     out_mis_q;
  logic                     out_clip_q;

  logic                in_acc;
  logic                out_free;
  logic                cur_bit;
  logic                last_bit;
  logic [MedianW-1:0]  med_cur;
  logic [MaskW-1:0]    shf_cur;
  logic [RemW-1:0]     thr_cur;
  logic [RemW-1:0]     rem_shift;
  logic [SkipW-1:0]    skip_next;
  logic [RemLeftW-1:0] rem_left_next;
  logic                sample_last;
  logic                ch_last;
  logic                delta_last;
  logic                mismatch;
  logic [DeltaW-1:0]   mag_shifted;
  logic                step_done;
  logic                clear_all;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign cur_bit       = byte_q[bit_idx_q];
  assign last_bit      = (bit_idx_q == '0);
  assign med_cur       = med_q[ch_q];
  assign shf_cur       = shf_q[ch_q];
  assign thr_cur       = extra_thr(med_cur);
  assign rem_shift     = {rem_q[RemW-2:0], cur_bit};
  assign skip_next     = (skip_q != '0) ? skip_q - 1'b1 : '0;
  assign rem_left_next = (rem_left_q != '0) ? rem_left_q - 1'b1 : '0;
  assign sample_last   = (sample_q == SampleW'(SamplesPerCh - 1));
  assign ch_last       = (ch_q == ChanW'(Channels - 1));
  assign delta_last    = sample_last && ch_last;
  assign mismatch      = delta_last && (cons_q != exp_q);
  assign mag_shifted   = DeltaW'(acc_q) << shf_cur;

  always_comb begin
    step_done = 1'b0;
    case (state_q)
      ST_BIT:   step_done = (phase_q != PH_SIGN) &&
                            !(phase_q == PH_SKIP && skip_next == '0);
      ST_EMIT:  step_done = out_free && !(sample_last && !ch_last);
      ST_ZERO:  step_done = out_free && delta_last;
      ST_START: step_done = 1'b1;
      default:  step_done = 1'b0;
    endcase
  end

  assign clear_all = (step_done && last_bit && end_q) ||
                     (in_acc && phase_q == PH_HEADER && in_i.packet_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HEADER;
      end_q       <= 1'b0;
      bit_idx_q   <= '0;
      hdr_cnt_q   <= '0;
      exp_q       <= '0;
      cons_q      <= '0;
      ch_q        <= '0;
      sample_q    <= '0;
      quot_q      <= '0;
      rem_q       <= '0;
      rem_left_q  <= '0;
      skip_q      <= '0;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        med_q[i] <= '0;
        shf_q[i] <= '0;
      end
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            byte_q <= in_i.packet_byte;
            end_q  <= in_i.packet_end;
            if (phase_q == PH_HEADER) begin
              hdr_cnt_q <= hdr_cnt_q + 1'b1;
              case (hdr_cnt_q)
                HdrMq0: begin
                  med_q[0] <= in_i.packet_byte[5:0];
                  shf_q[0] <= {2'b00, in_i.packet_byte[7:6]};
                end
                HdrMq1: begin
                  shf_q[0] <= {in_i.packet_byte[1:0], shf_q[0][1:0]};
                  med_q[1] <= in_i.packet_byte[7:2];
                end
                HdrMq2: begin
                  shf_q[1] <= in_i.packet_byte[3:0];
                  med_q[2] <= {2'b00, in_i.packet_byte[7:4]};
                end
                HdrMq3: begin
                  med_q[2] <= {in_i.packet_byte[1:0], med_q[2][3:0]};
                  shf_q[2] <= in_i.packet_byte[5:2];
                  med_q[3] <= {4'b0000, in_i.packet_byte[7:6]};
                end
                HdrMq4: begin
                  med_q[3] <= {in_i.packet_byte[3:0], med_q[3][1:0]};
                  shf_q[0] <= mask_to_shift(shf_q[0]);
                  shf_q[1] <= mask_to_shift(shf_q[1]);
                  shf_q[2] <= mask_to_shift(shf_q[2]);
                  shf_q[3] <= mask_to_shift(in_i.packet_byte[7:4]);
                end
                HdrLenHi: begin
                  exp_q <= {in_i.packet_byte, 8'h00};
                end
                HdrLenLo: begin
                  exp_q      <= {exp_q[LenW-1:ByteW], in_i.packet_byte};
                  cons_q     <= '0;
                  ch_q       <= '0;
                  sample_q   <= '0;
                  quot_q     <= '0;
                  rem_q      <= '0;
                  rem_left_q <= '0;
                  if (med_q[0] == '0) begin
                    phase_q <= PH_SKIP;
                    skip_q  <= SkipW'(ZeroSkipBits);
                  end else begin
                    phase_q <= PH_QUOT;
                  end
                end
                default: begin
                end
              endcase
            end else begin
              bit_idx_q <= BitIdxW'(ByteW - 1);
              state_q   <= ST_BIT;
            end
          end
        end

        ST_BIT: begin
          if (phase_q != PH_HEADER && phase_q != PH_DONE && cons_q != '1) begin
            cons_q <= cons_q + 1'b1;
          end
          case (phase_q)
            PH_SKIP: begin
              skip_q <= skip_next;
              if (skip_next == '0) begin
                state_q <= ST_ZERO;
              end
            end
            PH_QUOT: begin
              if (cur_bit) begin
                if (quot_q < QuotW'(MaxQuotient)) begin
                  quot_q <= quot_q + 1'b1;
                end
              end else begin
                rem_q      <= '0;
                rem_left_q <= (med_cur == MedianW'(1)) ? RemLeftW'(1) : floor_log2(med_cur);
                phase_q    <= PH_REM;
              end
            end
            PH_REM: begin
              rem_q      <= rem_shift;
              rem_left_q <= rem_left_next;
              if (rem_left_next == '0) begin
                phase_q <= (rem_shift >= thr_cur) ? PH_EXTRA : PH_SIGN;
              end
            end
            PH_EXTRA: begin
              rem_q   <= rem_shift - thr_cur;
              phase_q <= PH_SIGN;
            end
            PH_SIGN: begin
              sign_q    <= cur_bit;
              clip_q    <= (quot_q >= QuotW'(MaxQuotient));
              acc_q     <= MagW'(rem_q);
              mul_cnt_q <= '0;
              state_q   <= ST_MUL;
            end
            default: begin
            end
          endcase
        end

        ST_MUL: begin
          if (quot_q[mul_cnt_q]) begin
            acc_q <= acc_q + (MagW'(med_cur) << mul_cnt_q);
          end
          mul_cnt_q <= mul_cnt_q + 1'b1;
          if (mul_cnt_q == MulCntW'(QuotW - 1)) begin
            state_q <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_delta_q  <= sign_q ? signed'(-mag_shifted) : signed'(mag_shifted);
            out_ch_q     <= ch_q;
            out_sample_q <= sample_q;
            out_last_q   <= delta_last;
            out_mis_q    <= mismatch;
            out_clip_q   <= clip_q;
            quot_q       <= '0;
            rem_q        <= '0;
            if (sample_last) begin
              sample_q <= '0;
              if (ch_last) begin
                phase_q <= PH_DONE;
              end else begin
                ch_q    <= ch_q + 1'b1;
                state_q <= ST_START;
              end
            end else begin
              sample_q <= sample_q + 1'b1;
              phase_q  <= PH_QUOT;
            end
          end
        end

        ST_ZERO: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_delta_q  <= '0;
            out_ch_q     <= ch_q;
            out_sample_q <= sample_q;
            out_last_q   <= delta_last;
            out_mis_q    <= mismatch;
            out_clip_q   <= 1'b0;
            if (sample_last) begin
              sample_q <= '0;
              if (ch_last) begin
                phase_q <= PH_DONE;
              end else begin
                ch_q    <= ch_q + 1'b1;
                state_q <= ST_START;
              end
            end else begin
              sample_q <= sample_q + 1'b1;
            end
          end
        end

        ST_START: begin
          quot_q     <= '0;
          rem_q      <= '0;
          rem_left_q <= '0;
          if (med_cur == '0) begin
            phase_q <= PH_SKIP;
            skip_q  <= SkipW'(ZeroSkipBits);
          end else begin
            phase_q <= PH_QUOT;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (step_done) begin
        if (last_bit) begin
          state_q <= ST_IDLE;
        end else begin
          bit_idx_q <= bit_idx_q - 1'b1;
          state_q   <= ST_BIT;
        end
      end

      if (clear_all) begin
        phase_q    <= PH_HEADER;
        hdr_cnt_q  <= '0;
        exp_q      <= '0;
        cons_q     <= '0;
        ch_q       <= '0;
        sample_q   <= '0;
        quot_q     <= '0;
        rem_q      <= '0;
        rem_left_q <= '0;
        skip_q     <= '0;
        for (int i = 0; i < Channels; i++) begin
          med_q[i] <= '0;
          shf_q[i] <= '0;
        end
      end
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.delta_value      = out_delta_q;
  assign out_o.channel_index    = out_ch_q;
  assign out_o.sample_index     = out_sample_q;
  assign out_o.last_delta       = out_last_q;
  assign out_o.length_mismatch  = out_mis_q;
  assign out_o.quotient_clipped = out_clip_q;

  a_mul_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> mul_cnt_q <= MulCntW'(QuotW - 1))
    else $error("Multiply step count ran past the quotient width.");

  a_quot_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quot_q <= QuotW'(MaxQuotient))
    else $error("Quotient count exceeded its saturation limit.");

  a_mismatch_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.length_mismatch |-> out_o.last_delta)
    else $error("Length mismatch flagged on an item that is not the last delta.");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_delta |->
      out_o.channel_index == ChanW'(Channels - 1) &&
      out_o.sample_index == SampleW'(SamplesPerCh - 1))
    else $error("Last delta flagged away from the final channel and sample.");

  a_bit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q != PH_HEADER |=> state_q == ST_BIT && bit_idx_q == BitIdxW'(ByteW - 1))
    else $error("Bitstream byte accepted without starting the bit sequencer.");

endmodule

>>> tb/sv/tb_golomb_eeg_delta_decoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for golomb_eeg_delta_decoder_core: builds Golomb-coded packets,
// predicts every decoded delta in a behavioral decoder and checks each output item against it.
// Depends on ged_pkg, ged_in_if, ged_out_if and the decoder core.
module tb_golomb_eeg_delta_decoder_core;
  import ged_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned TrafficItems  = 24;

  typedef enum logic [2:0] {
    DecHeader, DecQuot, DecRem, DecExtra, DecSign, DecSkip, DecDone
  } dec_phase_e;

  typedef enum logic [1:0] {QuotShort, QuotMixed, QuotSaturate} quot_style_e;
  typedef enum logic [1:0] {RemZeros, RemRandom, RemOnes} rem_style_e;
  typedef enum logic [1:0] {LenTrue, LenOffset, LenFixed} len_style_e;

  typedef struct packed {
    logic [DeltaW-1:0]  value;
    logic [ChanW-1:0]   chan;
    logic [SampleW-1:0] smp;
    logic               last;
    logic               mismatch;
    logic               clipped;
  } delta_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ged_in_if  in_if ();
  ged_out_if out_if ();

  golomb_eeg_delta_decoder_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  delta_item_t exp_deltas[$];

  // Behavioral decoder state.
  logic [11:0]         hdr_bytes;
  logic [MedianW-1:0]  ch_median[Channels];
  logic [MaskW-1:0]    ch_shift[Channels];
  logic [LenW-1:0]     len_expected;
  logic [LenW-1:0]     len_parsed;
  dec_phase_e          phase;
  logic [ChanW-1:0]    cur_ch;
  logic [SampleW-1:0]  cur_smp;
  logic [QuotW-1:0]    quot_cnt;
  logic [RemW-1:0]     rem_acc;
  logic [RemLeftW-1:0] rem_left;
  logic [SkipW-1:0]    skip_left;

  // Packet plan used by the packet builder.
  logic [MedianW-1:0] plan_median[Channels];
  logic [MaskW-1:0]   plan_mask[Channels];
  quot_style_e        plan_quot[Channels];
  rem_style_e         plan_rem[Channels];
  len_style_e         plan_len;
  logic [LenW-1:0]    plan_len_arg;
  int unsigned        plan_lead_ones;
  int                 plan_keep;
  int unsigned        plan_tail;
  bit                 pkt_bits[$];

  function automatic int unsigned top_bit(input int unsigned m);
    int unsigned b;
    b = 0;
    while (b < 31 && (m >> (b + 1)) != 0) b++;
    return b;
  endfunction

  function automatic int unsigned extra_limit(input int unsigned m);
    return (32'd2 << top_bit(m)) - m;
  endfunction

  function automatic void clear_decoder();
    hdr_bytes    = '0;
    len_expected = '0;
    len_parsed   = '0;
    phase        = DecHeader;
    cur_ch       = '0;
    cur_smp      = '0;
    quot_cnt     = '0;
    rem_acc      = '0;
    rem_left     = '0;
    skip_left    = '0;
    for (int k = 0; k < Channels; k++) begin
      ch_median[k] = '0;
      ch_shift[k]  = '0;
    end
  endfunction

  function automatic void push_delta(input logic [31:0] v, input logic clip);
    delta_item_t d;
    d.value    = v[DeltaW-1:0];
    d.chan     = cur_ch;
    d.smp      = cur_smp;
    d.last     = (cur_ch == ChanW'(Channels - 1)) && (cur_smp == SampleW'(SamplesPerCh - 1));
    d.mismatch = d.last && (len_parsed != len_expected);
    d.clipped  = clip;
    exp_deltas.push_back(d);
  endfunction

  function automatic void begin_channel();
    quot_cnt = '0;
    rem_acc  = '0;
    rem_left = '0;
    if (ch_median[cur_ch] == '0) begin
      phase     = DecSkip;
      skip_left = SkipW'(ZeroSkipBits);
    end else begin
      phase = DecQuot;
    end
  endfunction

  function automatic void next_channel();
    cur_smp = '0;
    if (cur_ch == ChanW'(Channels - 1)) begin
      phase = DecDone;
    end else begin
      cur_ch = cur_ch + 1'b1;
      begin_channel();
    end
  endfunction

  function automatic void decode_bit(input logic b);
    int unsigned m;
    int unsigned mag;
    m = ch_median[cur_ch];
    if (phase == DecHeader || phase == DecDone) return;
    if (len_parsed != '1) len_parsed = len_parsed + 1'b1;
    case (phase)
      DecSkip: begin
        if (skip_left != '0) skip_left = skip_left - 1'b1;
        if (skip_left == '0) begin
          for (int s = 0; s < SamplesPerCh; s++) begin
            cur_smp = SampleW'(s);
            push_delta(32'd0, 1'b0);
          end
          next_channel();
        end
      end
      DecQuot: begin
        if (b) begin
          if (quot_cnt < QuotW'(MaxQuotient)) quot_cnt = quot_cnt + 1'b1;
        end else begin
          rem_acc  = '0;
          rem_left = (m == 1) ? RemLeftW'(1) : RemLeftW'(top_bit(m));
          phase    = DecRem;
        end
      end
      DecRem: begin
        rem_acc = {rem_acc[RemW-2:0], b};
        if (rem_left != '0) rem_left = rem_left - 1'b1;
        if (rem_left == '0) begin
          if (32'(rem_acc) >= extra_limit(m)) phase = DecExtra;
          else phase = DecSign;
        end
      end
      DecExtra: begin
        rem_acc = RemW'(32'({rem_acc, b}) - extra_limit(m));
        phase   = DecSign;
      end
      DecSign: begin
        mag = (32'(quot_cnt) * m + 32'(rem_acc)) << ch_shift[cur_ch];
        push_delta(b ? (32'd0 - mag) : mag, quot_cnt >= QuotW'(MaxQuotient));
        quot_cnt = '0;
        rem_acc  = '0;
        if (cur_smp == SampleW'(SamplesPerCh - 1)) begin
          next_channel();
        end else begin
          cur_smp = cur_smp + 1'b1;
          phase   = DecQuot;
        end
      end
      default: phase = DecDone;
    endcase
  endfunction

  function automatic void take_header(input logic [ByteW-1:0] b);
    int unsigned amt;
    case (hdr_bytes)
      12'(HdrMq0): begin
        ch_median[0] = b[5:0];
        ch_shift[0]  = {2'b00, b[7:6]};
      end
      12'(HdrMq1): begin
        ch_shift[0]  = ch_shift[0] | {b[1:0], 2'b00};
        ch_median[1] = b[7:2];
      end
      12'(HdrMq2): begin
        ch_shift[1]  = b[3:0];
        ch_median[2] = {2'b00, b[7:4]};
      end
      12'(HdrMq3): begin
        ch_median[2] = ch_median[2] | {b[1:0], 4'b0000};
        ch_shift[2]  = b[5:2];
        ch_median[3] = {4'b0000, b[7:6]};
      end
      12'(HdrMq4): begin
        ch_median[3] = ch_median[3] | {b[3:0], 2'b00};
        ch_shift[3]  = b[7:4];
        // The raw masks become shift amounts: mask bit k adds k+1.
        for (int c = 0; c < Channels; c++) begin
          amt = 0;
          for (int k = 0; k < MaskW; k++) begin
            if (ch_shift[c][k]) amt += k + 1;
          end
          ch_shift[c] = MaskW'(amt);
        end
      end
      12'(HdrLenHi): len_expected = {b, 8'h00};
      12'(HdrLenLo): begin
        len_expected[7:0] = b;
        len_parsed        = '0;
        cur_ch            = '0;
        cur_smp           = '0;
        begin_channel();
      end
      default: ;
    endcase
    if (hdr_bytes != 12'hFFF) hdr_bytes = hdr_bytes + 1'b1;
  endfunction

  function automatic void decode_item(input logic [ByteW-1:0] b, input logic e);
    if (phase == DecHeader) begin
      take_header(b);
    end else begin
      for (int i = ByteW - 1; i >= 0; i--) decode_bit(b[i]);
    end
    if (e) clear_decoder();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 100) begin
      $display("ERROR cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    delta_item_t want;
    if (rst_ni === 1'b1) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (exp_deltas.size() == 0) begin
          report_mismatch("unexpected delta_value", 32'(out_if.delta_value), 32'd0);
        end else begin
          want = exp_deltas.pop_front();
          if (out_if.delta_value !== want.value)
            report_mismatch("delta_value", 32'(out_if.delta_value), 32'(want.value));
          if (out_if.channel_index !== want.chan)
            report_mismatch("channel_index", 32'(out_if.channel_index), 32'(want.chan));
          if (out_if.sample_index !== want.smp)
            report_mismatch("sample_index", 32'(out_if.sample_index), 32'(want.smp));
          if (out_if.last_delta !== want.last)
            report_mismatch("last_delta", 32'(out_if.last_delta), 32'(want.last));
          if (out_if.length_mismatch !== want.mismatch)
            report_mismatch("length_mismatch", 32'(out_if.length_mismatch),
                            32'(want.mismatch));
          if (out_if.quotient_clipped !== want.clipped)
            report_mismatch("quotient_clipped", 32'(out_if.quotient_clipped),
                            32'(want.clipped));
        end
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        decode_item(in_if.packet_byte, in_if.packet_end);
      end
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("golomb_eeg_delta_decoder_core verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic [ByteW-1:0] b, input logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.packet_byte <= b;
    in_if.packet_end  <= e;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic bit rem_bit(input rem_style_e st);
    case (st)
      RemZeros: return 1'b0;
      RemOnes:  return 1'b1;
      default:  return 1'($urandom_range(1));
    endcase
  endfunction

  task automatic send_packet();
    int unsigned m, nb, acc, ones, nbits, nbytes, keep, total, idx;
    logic [LenW-1:0]  len_field;
    logic [ByteW-1:0] hdr[8];
    logic [ByteW-1:0] v;
    bit               r;
    pkt_bits.delete();
    for (int ch = 0; ch < Channels; ch++) begin
      m = plan_median[ch];
      if (m == 0) begin
        repeat (ZeroSkipBits) pkt_bits.push_back(1'($urandom_range(1)));
      end else begin
        for (int s = 0; s < SamplesPerCh; s++) begin
          ones = 0;
          case (plan_quot[ch])
            QuotMixed: begin
              r = 1'b0;
              acc = $urandom_range(99);
              if (acc < 78) ones = $urandom_range(1);
              else if (acc < 97) ones = $urandom_range(6, 2);
              else ones = $urandom_range(MaxQuotient + 4, MaxQuotient - 1);
            end
            QuotSaturate: if (s == 0) ones = $urandom_range(MaxQuotient + 9, MaxQuotient);
            default: ones = 0;
          endcase
          if (ch == 0 && s == 0 && plan_lead_ones > 0) ones = plan_lead_ones;
          repeat (ones) pkt_bits.push_back(1'b1);
          pkt_bits.push_back(1'b0);
          nb  = (m == 1) ? 1 : top_bit(m);
          acc = 0;
          repeat (nb) begin
            r   = rem_bit(plan_rem[ch]);
            acc = 2 * acc + r;
            pkt_bits.push_back(r);
          end
          if (acc >= extra_limit(m)) pkt_bits.push_back(rem_bit(plan_rem[ch]));
          pkt_bits.push_back(1'($urandom_range(1)));
        end
      end
    end
    nbits = pkt_bits.size();
    while (pkt_bits.size() % ByteW != 0) pkt_bits.push_back(1'($urandom_range(1)));
    case (plan_len)
      LenOffset: len_field = LenW'(nbits + plan_len_arg);
      LenFixed:  len_field = plan_len_arg;
      default:   len_field = LenW'(nbits);
    endcase
    hdr[0] = ByteW'($urandom_range(255));
    hdr[1] = {plan_mask[0][1:0], plan_median[0]};
    hdr[2] = {plan_median[1], plan_mask[0][3:2]};
    hdr[3] = {plan_median[2][3:0], plan_mask[1]};
    hdr[4] = {plan_median[3][1:0], plan_mask[2], plan_median[2][5:4]};
    hdr[5] = {plan_mask[3], plan_median[3][5:2]};
    hdr[6] = len_field[15:8];
    hdr[7] = len_field[7:0];
    nbytes = pkt_bits.size() / ByteW;
    keep   = (plan_keep < 0 || plan_keep > int'(nbytes)) ? nbytes : plan_keep;
    total  = 8 + keep + plan_tail;
    idx    = 0;
    for (int i = 0; i < 8; i++) begin
      send_item(hdr[i], idx == total - 1);
      idx++;
    end
    for (int d = 0; d < int'(keep); d++) begin
      v = '0;
      for (int k = 0; k < ByteW; k++) v = {v[ByteW-2:0], pkt_bits[ByteW * d + k]};
      send_item(v, idx == total - 1);
      idx++;
    end
    repeat (plan_tail) begin
      send_item(ByteW'($urandom_range(255)), idx == total - 1);
      idx++;
    end
  endtask

  function automatic void randomize_plan();
    int unsigned r;
    for (int ch = 0; ch < Channels; ch++) begin
      r = $urandom_range(99);
      if (r < 25) plan_median[ch] = '0;
      else if (r < 45) plan_median[ch] = 6'd1;
      else if (r < 65) plan_median[ch] = MedianW'($urandom_range(7, 2));
      else if (r < 85) plan_median[ch] = MedianW'($urandom_range(62, 8));
      else plan_median[ch] = 6'd63;
      plan_mask[ch] = MaskW'($urandom_range(15));
      r = $urandom_range(99);
      plan_quot[ch] = (r < 85) ? QuotMixed : (r < 95) ? QuotShort : QuotSaturate;
      r = $urandom_range(99);
      plan_rem[ch] = (r < 80) ? RemRandom : (r < 90) ? RemZeros : RemOnes;
    end
    r = $urandom_range(99);
    plan_len       = (r < 80) ? LenTrue : (r < 95) ? LenOffset : LenFixed;
    plan_len_arg   = LenW'($urandom_range(65535, 1));
    plan_lead_ones = 0;
    plan_keep      = ($urandom_range(99) < 85) ? -1 : int'($urandom_range(20));
    plan_tail      = ($urandom_range(99) < 80) ? 0 : $urandom_range(4, 1);
  endfunction

  // Largest magnitudes, a one-valued median with all-ones remainders, a zero-median skip and
  // negative zeros, with a wrong bit length in the header.
  task automatic test_extreme_packet();
    plan_median    = '{6'd63, 6'd1, 6'd0, 6'd2};
    plan_mask      = '{4'hF, 4'h0, 4'h5, 4'hA};
    plan_quot      = '{QuotSaturate, QuotShort, QuotShort, QuotMixed};
    plan_rem       = '{RemOnes, RemOnes, RemRandom, RemZeros};
    plan_len       = LenOffset;
    plan_len_arg   = 16'h8000;
    plan_lead_ones = 0;
    plan_keep      = -1;
    plan_tail      = 0;
    send_packet();
  endtask

  task automatic test_short_packets();
    repeat (3) send_item(ByteW'($urandom_range(255)), 1'b0);
    send_item(ByteW'($urandom_range(255)), 1'b1);
    randomize_plan();
    plan_keep = 0;
    plan_tail = 0;
    send_packet();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned start;
    int unsigned n;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    start = items_sent;
    while (items_sent - start < TrafficItems) begin
      if ($urandom_range(99) < 12) begin
        n = $urandom_range(12, 1);
        for (int i = 0; i < int'(n); i++) begin
          send_item(ByteW'($urandom_range(255)),
                    (i == int'(n) - 1) || ($urandom_range(7) == 0));
        end
      end else begin
        randomize_plan();
        send_packet();
      end
    end
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.packet_byte <= '0;
    in_if.packet_end  <= 1'b0;
    rst_ni            <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    clear_decoder();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_packet();
    test_short_packets();
    test_random_traffic(0, 0);
    test_random_traffic(64, 0);
    test_random_traffic(0, 64);
    test_random_traffic(23, 23);
    in_if.valid <= 1'b0;
    while (exp_deltas.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("golomb_eeg_delta_decoder_core verification clean");
    end else begin
      $display("golomb_eeg_delta_decoder_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ged_pkg.sv
sv/ged_in_if.sv
sv/ged_out_if.sv
sv/golomb_eeg_delta_decoder_core.sv
tb/sv/tb_golomb_eeg_delta_decoder_core.sv
